// ===== rtl/lcd9_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lcd9_pkg;

  localparam int WORD_BITS  = 9;
  localparam int BYTE_BITS  = 8;
  localparam int ACC_BITS   = 16;
  localparam int ACC_CNT_W  = 5;
  localparam int Q_DEPTH    = 4;
  localparam int Q_PTR_W    = 2;
  localparam int Q_CNT_W    = 3;

  localparam logic [0:0] REG_SWAP_PAIRS = 1'b0;

  typedef struct packed {
    logic       is_data;
    logic [7:0] value;
    logic       end_of_transfer;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       chunk_end;
    logic       frame_end;
  } out_item_t;

  // one 9-bit word for the packer, eot marks the last word of a transfer
  typedef struct packed {
    logic       dc;
    logic [7:0] value;
    logic       eot;
  } word_t;

endpackage

`default_nettype wire

// ===== rtl/lcd9_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lcd9_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcd9_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcd9_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              swap_pairs,
  input  logic              in_valid,
  input  lcd9_pkg::in_item_t in_data,
  output logic              in_ready,
  output logic              push,
  output lcd9_pkg::word_t   push_word,
  input  logic              q_full
);

  logic            held_v_r, held_v_nxt;
  logic [7:0]      held_r, held_nxt;
  logic            sec_v_r, sec_v_nxt;
  lcd9_pkg::word_t sec_r, sec_nxt;

  logic            accept;
  logic            hold_case;
  logic            pair_case;
  logic            two_words;
  lcd9_pkg::word_t first_w;
  lcd9_pkg::word_t second_w;

  assign in_ready = !sec_v_r && !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    hold_case = swap_pairs && in_data.is_data && !held_v_r && !in_data.end_of_transfer;
    pair_case = swap_pairs && in_data.is_data && held_v_r;
    two_words = 1'b0;
    first_w   = '{dc: in_data.is_data, value: in_data.value, eot: in_data.end_of_transfer};
    second_w  = first_w;
    if (pair_case) begin
      // pixel byte order: newer byte goes out first
      two_words = 1'b1;
      first_w   = '{dc: 1'b1, value: in_data.value, eot: 1'b0};
      second_w  = '{dc: 1'b1, value: held_r, eot: in_data.end_of_transfer};
    end else if (held_v_r) begin
      two_words = 1'b1;
      first_w   = '{dc: 1'b1, value: held_r, eot: 1'b0};
      second_w  = '{dc: in_data.is_data, value: in_data.value,
                    eot: in_data.end_of_transfer};
    end
  end

  assign push      = sec_v_r ? !q_full : (accept && !hold_case);
  assign push_word = sec_v_r ? sec_r : first_w;

  always_comb begin
    held_v_nxt = held_v_r;
    held_nxt   = held_r;
    sec_v_nxt  = sec_v_r;
    sec_nxt    = sec_r;
    if (sec_v_r && !q_full) begin
      sec_v_nxt = 1'b0;
    end
    if (accept) begin
      if (hold_case) begin
        held_v_nxt = 1'b1;
        held_nxt   = in_data.value;
      end else begin
        held_v_nxt = 1'b0;
        sec_v_nxt  = two_words;
        sec_nxt    = second_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      held_r   <= '0;
      sec_v_r  <= 1'b0;
    end else begin
      held_v_r <= held_v_nxt;
      held_r   <= held_nxt;
      sec_v_r  <= sec_v_nxt;
    end
    sec_r <= sec_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/lcd9_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcd9_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lcd9_pkg::word_t push_word,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lcd9_pkg::word_t head
);

  lcd9_pkg::word_t                 mem_r [lcd9_pkg::Q_DEPTH];
  logic [lcd9_pkg::Q_PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [lcd9_pkg::Q_CNT_W-1:0]    cnt_r;
  logic                            do_push, do_pop;

  assign full      = (cnt_r == lcd9_pkg::Q_CNT_W'(lcd9_pkg::Q_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_word;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lcd9_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcd9_back #(
  parameter int CHUNK_BYTES = 126
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                word_valid,
  input  lcd9_pkg::word_t     word,
  output logic                pop,
  output logic                out_valid,
  output lcd9_pkg::out_item_t out_data,
  input  logic                out_ready
);

  localparam int CNT_W = $clog2(CHUNK_BYTES);

  logic [lcd9_pkg::ACC_BITS-1:0]  acc_r, acc_nxt, acc_e;
  logic [lcd9_pkg::ACC_CNT_W-1:0] fill_r, fill_nxt, fill_e;
  logic                           pend_r, pend_nxt;
  logic [CNT_W-1:0]               chunk_r, chunk_nxt;
  logic                           out_v_r, out_v_nxt;
  lcd9_pkg::out_item_t            out_r, out_nxt;

  logic                           can_out;
  logic                           have_byte;
  logic                           emit;
  logic                           fe;
  logic                           ce;
  logic [lcd9_pkg::ACC_BITS-1:0]  word_bits;

  assign can_out   = !out_v_r || out_ready;
  assign have_byte = (fill_r >= lcd9_pkg::ACC_CNT_W'(lcd9_pkg::BYTE_BITS));
  assign emit      = can_out && (have_byte || (pend_r && (fill_r != '0)));
  // last byte of a transfer: exactly one byte left, or the zero padded rest
  assign fe        = pend_r &&
                     (!have_byte || (fill_r == lcd9_pkg::ACC_CNT_W'(lcd9_pkg::BYTE_BITS)));
  assign ce        = fe || (chunk_r == CNT_W'(CHUNK_BYTES - 1));

  assign word_bits = {word.dc, word.value,
                      (lcd9_pkg::ACC_BITS - lcd9_pkg::WORD_BITS)'(0)};

  always_comb begin
    acc_e  = acc_r;
    fill_e = fill_r;
    if (emit) begin
      acc_e  = acc_r << lcd9_pkg::BYTE_BITS;
      fill_e = have_byte ? fill_r - lcd9_pkg::ACC_CNT_W'(lcd9_pkg::BYTE_BITS) : '0;
    end
  end

  assign pop = word_valid && !pend_r && (fill_e < lcd9_pkg::ACC_CNT_W'(lcd9_pkg::BYTE_BITS));

  always_comb begin
    acc_nxt   = acc_e;
    fill_nxt  = fill_e;
    pend_nxt  = pend_r && !(emit && fe);
    chunk_nxt = chunk_r;
    out_v_nxt = out_v_r && !out_ready;
    out_nxt   = out_r;
    if (pop) begin
      acc_nxt  = acc_e | (word_bits >> fill_e[2:0]);
      fill_nxt = fill_e + lcd9_pkg::ACC_CNT_W'(lcd9_pkg::WORD_BITS);
      pend_nxt = word.eot;
    end
    if (emit) begin
      chunk_nxt = ce ? '0 : chunk_r + 1'b1;
      out_v_nxt = 1'b1;
      out_nxt   = '{out_byte: acc_r[lcd9_pkg::ACC_BITS-1 -: lcd9_pkg::BYTE_BITS],
                    chunk_end: ce, frame_end: fe};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      fill_r  <= '0;
      pend_r  <= 1'b0;
      chunk_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      acc_r   <= acc_nxt;
      fill_r  <= fill_nxt;
      pend_r  <= pend_nxt;
      chunk_r <= chunk_nxt;
      out_v_r <= out_v_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/lcd_9bit_spi_word_packer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Packs 9-bit LCD words (DC bit then eight bits) MSB first into a byte stream. The front
// takes one request per cycle unless its second word or a full queue stalls it, and
// makes zero, one or two words (none when swap mode holds a data byte, two when a held
// byte goes out, reversed if the new item is data); a four-word queue feeds the back,
// which shifts one word a cycle into a 16-bit accumulator while under eight bits wait
// and no transfer end is pending, and sends at most one byte a cycle through a
// registered output that sets the sustained rate. A transfer's final byte is zero padded
// when bits are left over. chunk_end marks every CHUNK_BYTES-th byte and the last byte
// of a transfer, which frame_end also marks. Register swap_pairs is at byte address 0.
module lcd_9bit_spi_word_packer #(
  parameter int CHUNK_BYTES = 126
) (
  input  logic                 clk,
  input  logic                 rst_n,
  lcd9_stream_if.sink          in_ch,
  lcd9_stream_if.source        out_ch,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic            swap_pairs_r;
  logic            q_push, q_full, q_pop, q_not_empty;
  lcd9_pkg::word_t q_in_word, q_head;
  logic            cfg_sel_swap;

  assign cfg_pready   = 1'b1;
  assign cfg_sel_swap = (cfg_paddr[2:2] == lcd9_pkg::REG_SWAP_PAIRS);
  assign cfg_prdata   = cfg_sel_swap ? {31'b0, swap_pairs_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swap_pairs_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_swap) begin
      swap_pairs_r <= cfg_pwdata[0];
    end
  end

  lcd9_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .swap_pairs (swap_pairs_r),
    .in_valid   (in_ch.valid),
    .in_data    (in_ch.data),
    .in_ready   (in_ch.ready),
    .push       (q_push),
    .push_word  (q_in_word),
    .q_full     (q_full)
  );

  lcd9_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in_word),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  lcd9_back #(
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .word_valid (q_not_empty),
    .word       (q_head),
    .pop        (q_pop),
    .out_valid  (out_ch.valid),
    .out_data   (out_ch.data),
    .out_ready  (out_ch.ready)
  );

endmodule

`default_nettype wire

// ===== rtl/lcd9_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lcd9_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input lcd9_pkg::out_item_t out_data
);

  // a transfer end always closes a burst
  a_frame_closes_chunk: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.frame_end) |-> out_data.chunk_end)
    else $error("frame_end without chunk_end");

  a_out_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("output request dropped while stalled");

  a_out_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("output request changed while stalled");

  a_quiet_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("output request right after reset");

endmodule

bind lcd_9bit_spi_word_packer lcd9_checker u_lcd9_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
